### src/jrb_pkg.sv
// ----------------------------------------------------------------------------
// jrb_pkg: shared types and constants of the retry backoff scheduler
// Word layouts, sizing constants, generator constants and sequencer states.
// ----------------------------------------------------------------------------
package jrb_pkg;

  // Sizing of the cap arithmetic and the retry counter.
  localparam int MAX_EXPONENT = 64;
  localparam int CAP_WIDTH    = 40;
  localparam int COUNT_WIDTH  = 16;

  // Cap in Q.8 form, the exact step sum, and the step counter.
  localparam int M_W   = CAP_WIDTH + 8;
  localparam int T_W   = CAP_WIDTH + 13;
  localparam int EXP_W = $clog2(MAX_EXPONENT + 1);
  // The clamped delay may be as wide as a floor or ceiling register.
  localparam int DLY_W = (CAP_WIDTH > 32) ? CAP_WIDTH : 32;

  // Field widths of the result word.
  localparam int ATTEMPT_W = 16;
  localparam int DELAY_W   = 40;

  localparam logic [63:0]          RNG_SEED  = 64'd88172645463393265;
  localparam logic [63:0]          RNG_MUL   = 64'd2685821657736338717;
  localparam logic [31:0]          NS_PER_MS = 32'd1000000;
  localparam logic [M_W-1:0]       CAP_INIT  = M_W'(100 << 8);
  localparam logic [M_W-1:0]       M_MAX     = {M_W{1'b1}};
  localparam logic [CAP_WIDTH-1:0] CAP_MAX   = {CAP_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [11:0]          FACTOR_DEFAULT = 12'd512;
  localparam logic [8:0]           RETRIES_UNLIMITED = 9'h1FF;

  // Configuration register map.
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_FACTOR  = 3'd0;
  localparam logic [2:0] REG_MIN     = 3'd1;
  localparam logic [2:0] REG_MAX     = 3'd2;
  localparam logic [2:0] REG_JITTER  = 3'd3;
  localparam logic [2:0] REG_RETRIES = 3'd4;

  // Remainder unit: one dividend bit per cycle.
  localparam int DIV_STEPS = 64;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_RETRY = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] now_ns;
  } in_word_t;

  typedef struct packed {
    logic                 granted;
    logic [ATTEMPT_W-1:0] attempt_number;
    logic [DELAY_W-1:0]   backoff_ms;
    logic [63:0]          retry_at_ns;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAP_LO,
    ST_CAP_HI,
    ST_CAP_ACC,
    ST_RNG0,
    ST_RNG1,
    ST_RNG2,
    ST_RNG3,
    ST_DIV,
    ST_NS0,
    ST_NS1,
    ST_NS2,
    ST_EMIT
  } state_t;

endpackage

### src/jrb_mul.sv
// ----------------------------------------------------------------------------
// jrb_mul: shared 32x32 multiplier
// Unsigned product, registered; every 32x32 multiplication of the block uses it.
// ----------------------------------------------------------------------------
module jrb_mul (
  input  logic        clk,
  input  logic [31:0] mul_a,
  input  logic [31:0] mul_b,
  output logic [63:0] mul_prod
);

  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  assign mul_prod = prod_r;

endmodule

### src/jrb_mod.sv
// ----------------------------------------------------------------------------
// jrb_mod: iterative remainder unit
// Restoring division of a 64-bit word, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module jrb_mod (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [63:0]          dividend,
  input  logic [jrb_pkg::CAP_WIDTH:0] divisor,
  output logic                 done,
  output logic [jrb_pkg::CAP_WIDTH:0] rem
);
  import jrb_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [63:0]         dvd_r, dvd_nxt;
  logic [CAP_WIDTH:0]  div_r, div_nxt;
  logic [CAP_WIDTH:0]  rem_r, rem_nxt;
  logic [CAP_WIDTH+1:0] shifted;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    shifted  = {rem_r, dvd_r[63]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(DIV_STEPS);
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so it fits again.
      if (shifted >= {1'b0, div_r}) begin
        rem_nxt = (CAP_WIDTH+1)'(shifted - {1'b0, div_r});
      end else begin
        rem_nxt = (CAP_WIDTH+1)'(shifted);
      end
      dvd_nxt = {dvd_r[62:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### src/jittered_retry_backoff.sv
// ----------------------------------------------------------------------------
// jittered_retry_backoff: retry scheduler with exponential backoff and jitter
// Sequencer, configuration registers and generator state around one shared
// multiplier and one iterative remainder unit.
// ----------------------------------------------------------------------------
// Usage: each input word carries a kind (start or retry) and the current time
// in nanoseconds; each one produces exactly one result word with the grant
// flag, the retry count, the chosen delay in ms and the retry time in ns.
// The block takes one word at a time: in_stall is high from acceptance until
// the result is placed in the output register. A start word or a refused
// retry goes straight from acceptance to the emit state, which loads the
// output register. A granted retry first runs s cap growth steps, where s is
// min(count, 64), or fewer when the cap saturates, each using the shared
// 32x32 multiplier; then the xorshift64* step and its 64-bit product, the wait
// on the 64-step bit-serial remainder unit, the forming of now + delay * 1e6
// and the load of the output register. While out_stall is high the result
// holds, and the next input word is already accepted meanwhile. A second
// finished result waits in the sequencer until the register frees. Reset
// (synchronous, active low) restores the register defaults, seeds the
// generator and clears the retry count. Registers are to be written over the
// APB port only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module jittered_retry_backoff (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  jrb_pkg::in_word_t        in_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output jrb_pkg::out_word_t       out_word,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [jrb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import jrb_pkg::*;

  // One xorshift64 step of the generator word.
  function automatic logic [63:0] xorshift(input logic [63:0] x_in);
    logic [63:0] x;
    x = x_in;
    x = x ^ (x >> 12);
    x = x ^ (x << 25);
    x = x ^ (x >> 27);
    return x;
  endfunction

  state_t state_r, state_nxt;

  logic [11:0] factor_r;
  logic [31:0] min_r;
  logic [31:0] max_r;
  logic        full_r;
  logic [8:0]  retries_r;

  logic [63:0]            rng_r, rng_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [63:0]            now_r, now_nxt;
  logic [M_W-1:0]         m_r, m_nxt;
  logic [EXP_W-1:0]       steps_r, steps_nxt;
  logic                   sat_r, sat_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic [DLY_W-1:0]       delay_r, delay_nxt;
  logic [63:0]            retry_at_r, retry_at_nxt;
  logic                   granted_r, granted_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_word_r, out_word_nxt;

  logic [31:0]          mul_a, mul_b;
  logic [63:0]          mul_prod;
  logic                 div_start;
  logic [63:0]          div_dividend;
  logic [CAP_WIDTH:0]   div_divisor;
  logic                 div_done;
  logic [CAP_WIDTH:0]   div_rem;

  logic                   cfg_write;
  logic                   in_accept;
  logic                   retry_ok;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [11:0]            f_eff;
  logic [CAP_WIDTH-1:0]   hi;
  logic [63:0]            hi_ext;
  logic [19:0]            lo_prod;
  logic [T_W-1:0]         step_sum;
  logic [CAP_WIDTH-1:0]   cap;
  logic [CAP_WIDTH-1:0]   half;
  logic [63:0]            xs;
  logic [CAP_WIDTH:0]     base;
  logic [DLY_W-1:0]       clamped;
  logic [63:0]            delay_ext;

  jrb_mul u_mul (
    .clk      (clk),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .mul_prod (mul_prod)
  );

  jrb_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r  <= FACTOR_DEFAULT;
      min_r     <= '0;
      max_r     <= '0;
      full_r    <= 1'b1;
      retries_r <= '0;
    end else if (cfg_write) begin
      // Writes to addresses past the last register are dropped.
      unique case (paddr[ADDR_W-1:2])
        REG_FACTOR:  factor_r  <= pwdata[11:0];
        REG_MIN:     min_r     <= pwdata;
        REG_MAX:     max_r     <= pwdata;
        REG_JITTER:  full_r    <= pwdata[0];
        REG_RETRIES: retries_r <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_FACTOR:  prdata = 32'(factor_r);
      REG_MIN:     prdata = min_r;
      REG_MAX:     prdata = max_r;
      REG_JITTER:  prdata = 32'(full_r);
      REG_RETRIES: prdata = 32'(retries_r);
      default:     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath terms shared by the sequencer states
  // --------------------------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // A limit of -1 is unlimited, any other negative limit refuses everything.
  always_comb begin
    if (retries_r == RETRIES_UNLIMITED) begin
      retry_ok = 1'b1;
    end else if (retries_r[8]) begin
      retry_ok = 1'b0;
    end else begin
      retry_ok = (count_r < COUNT_WIDTH'(retries_r[7:0]));
    end
  end

  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;

  // The cap grows as m = floor(m * f / 256), split into the integer part times
  // f (two passes of the multiplier) plus the fraction times f.
  assign f_eff    = (factor_r == 12'd0) ? FACTOR_DEFAULT : factor_r;
  assign hi       = m_r[M_W-1:8];
  assign hi_ext   = 64'(hi);
  assign lo_prod  = 20'(m_r[7:0]) * 20'(f_eff);
  assign step_sum = T_W'(acc_r) + (T_W'(mul_prod) << 32) + T_W'(lo_prod[19:8]);

  assign cap  = sat_r ? CAP_MAX : m_r[M_W-1:8];
  assign half = cap >> 1;

  assign xs = xorshift(rng_r);

  // Low 64 bits of the generator product, finished as the third partial
  // product comes out of the multiplier.
  assign div_dividend = {acc_r[63:32] + mul_prod[31:0], acc_r[31:0]};
  assign div_divisor  = full_r ? ({1'b0, cap} + 1'b1) : ({1'b0, half} + 1'b1);

  // Half jitter starts the draw at half the cap; either way base <= cap.
  assign base = full_r ? div_rem : ({1'b0, half} + div_rem);

  // The floor is applied first, so a ceiling below it wins.
  always_comb begin
    clamped = DLY_W'(base[CAP_WIDTH-1:0]);
    if ((min_r != 32'd0) && (64'(clamped) < 64'(min_r))) begin
      clamped = DLY_W'(min_r);
    end
    if ((max_r != 32'd0) && (64'(clamped) > 64'(max_r))) begin
      clamped = DLY_W'(max_r);
    end
  end

  assign delay_ext = 64'(delay_r);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    rng_nxt       = rng_r;
    count_nxt     = count_r;
    now_nxt       = now_r;
    m_nxt         = m_r;
    steps_nxt     = steps_r;
    sat_nxt       = sat_r;
    acc_nxt       = acc_r;
    delay_nxt     = delay_r;
    retry_at_nxt  = retry_at_r;
    granted_nxt   = granted_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          now_nxt      = in_word.now_ns;
          retry_at_nxt = in_word.now_ns;
          granted_nxt  = 1'b0;
          delay_nxt    = '0;
          if (in_word.kind == KIND_START) begin
            count_nxt = '0;
            state_nxt = ST_EMIT;
          end else if (retry_ok) begin
            count_nxt   = count_inc;
            granted_nxt = 1'b1;
            m_nxt       = CAP_INIT;
            sat_nxt     = 1'b0;
            if (32'(count_inc) > 32'(MAX_EXPONENT)) begin
              steps_nxt = EXP_W'(MAX_EXPONENT);
            end else begin
              steps_nxt = EXP_W'(count_inc);
            end
            state_nxt = ST_CAP_LO;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end

      ST_CAP_LO: begin
        mul_a     = hi_ext[31:0];
        mul_b     = 32'(f_eff);
        state_nxt = ST_CAP_HI;
      end

      ST_CAP_HI: begin
        mul_a     = hi_ext[63:32];
        mul_b     = 32'(f_eff);
        acc_nxt   = mul_prod;
        state_nxt = ST_CAP_ACC;
      end

      ST_CAP_ACC: begin
        steps_nxt = steps_r - 1'b1;
        // Past the Q.8 limit the cap saturates and later steps are skipped.
        if (step_sum > T_W'(M_MAX)) begin
          sat_nxt   = 1'b1;
          state_nxt = ST_RNG0;
        end else begin
          m_nxt = step_sum[M_W-1:0];
          if (steps_r == EXP_W'(1)) begin
            state_nxt = ST_RNG0;
          end else begin
            state_nxt = ST_CAP_LO;
          end
        end
      end

      ST_RNG0: begin
        rng_nxt   = xs;
        mul_a     = xs[31:0];
        mul_b     = RNG_MUL[31:0];
        state_nxt = ST_RNG1;
      end

      ST_RNG1: begin
        mul_a     = rng_r[31:0];
        mul_b     = RNG_MUL[63:32];
        acc_nxt   = mul_prod;
        state_nxt = ST_RNG2;
      end

      ST_RNG2: begin
        mul_a     = rng_r[63:32];
        mul_b     = RNG_MUL[31:0];
        acc_nxt   = {acc_r[63:32] + mul_prod[31:0], acc_r[31:0]};
        state_nxt = ST_RNG3;
      end

      ST_RNG3: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end

      ST_DIV: begin
        if (div_done) begin
          delay_nxt = clamped;
          state_nxt = ST_NS0;
        end
      end

      ST_NS0: begin
        mul_a     = delay_ext[31:0];
        mul_b     = NS_PER_MS;
        state_nxt = ST_NS1;
      end

      ST_NS1: begin
        mul_a     = delay_ext[63:32];
        mul_b     = NS_PER_MS;
        acc_nxt   = mul_prod;
        state_nxt = ST_NS2;
      end

      ST_NS2: begin
        retry_at_nxt = now_r + {acc_r[63:32] + mul_prod[31:0], acc_r[31:0]};
        state_nxt    = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_word_nxt.granted        = granted_r;
          out_word_nxt.attempt_number = ATTEMPT_W'(count_r);
          out_word_nxt.backoff_ms     = DELAY_W'(delay_r);
          out_word_nxt.retry_at_ns    = retry_at_r;
          out_valid_nxt               = 1'b1;
          state_nxt                   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rng_r       <= RNG_SEED;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rng_r       <= rng_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    m_r        <= m_nxt;
    steps_r    <= steps_nxt;
    sat_r      <= sat_nxt;
    acc_r      <= acc_nxt;
    delay_r    <= delay_nxt;
    retry_at_r <= retry_at_nxt;
    granted_r  <= granted_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the jittered retry backoff scheduler
// Drives a directed plan, then start and retry words under randomly changing register settings, and
// compares every result word with a bit-accurate scheduler written inline or a hand-typed one.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jrb_pkg::*;

  // Run sizing. The quiet stretch at the end has no idling on either side.
  localparam int ITEMS       = 1100;
  localparam int QUIET_ITEMS = 100;
  // Length of the one long receiver hold-off that fills the block up.
  localparam int HOLD_CYCLES = 400;
  // The tail wait after the last result outlasts a granted retry at a high count.
  localparam int TAIL_CYCLES = 300;
  // The longest correct stretch without any handshake is the long hold-off;
  // the watchdog limit is a good many times that.
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_PRINTS  = 100;

  // Indexes past the register map; writes there must leave everything alone.
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  // A negative limit other than -1 refuses every retry.
  localparam logic [8:0] RETRIES_REFUSE_ALL = 9'h1FE;

  localparam logic [63:0] MS_TO_NS = 64'(NS_PER_MS);
  localparam logic [63:0] Q8_LIMIT = 64'(M_MAX);
  localparam logic [63:0] CAP_SAT  = 64'(CAP_MAX);
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic {
    ROW_REG,
    ROW_WORD
  } row_kind_t;

  // One row of the directed plan: either a register write or one input word,
  // optionally with its result typed in by hand.
  typedef struct {
    row_kind_t   what;
    logic [2:0]  idx;
    logic [31:0] value;
    kind_t       kind;
    logic [63:0] now;
    bit          typed;
    out_word_t   result;
  } plan_row_t;

  logic              clk;
  logic              rst_n    = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_word_t          in_word  = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_word_t         out_word;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [31:0]       pwdata   = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Shadow copy of the registers and of the scheduler state.
  logic [11:0]            shadow_factor;
  logic [31:0]            shadow_floor;
  logic [31:0]            shadow_ceiling;
  logic                   shadow_full;
  logic [8:0]             shadow_retries;
  logic [63:0]            shadow_rng;
  logic [COUNT_WIDTH-1:0] shadow_count;

  // Result words still owed by the block, oldest first.
  out_word_t due_results[$];
  plan_row_t plan[$];

  int mismatches = 0;
  int words_sent = 0;
  bit quiet      = 1'b0;
  bit hold_req   = 1'b0;
  bit hold_done  = 1'b0;

  jittered_retry_backoff DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Scheduler prediction
  // --------------------------------------------------------------------------

  // Cap in ms for a given attempt: the Q.8 value starts at 100 ms and is
  // multiplied by the factor once per attempt, up to the exponent limit.
  // Any step that would overflow the Q.8 range pins the cap at its maximum.
  function automatic logic [63:0] backoff_cap(input logic [COUNT_WIDTH-1:0] attempt);
    logic [63:0] f, m, hi, lo, add, t;
    int          steps, i;
    f = (shadow_factor == '0) ? 64'(FACTOR_DEFAULT) : 64'(shadow_factor);
    m = 64'(CAP_INIT);
    steps = (attempt < 1) ? 1 : int'(attempt);
    if (steps > MAX_EXPONENT) steps = MAX_EXPONENT;
    for (i = 0; i < steps; i++) begin
      hi  = m >> 8;
      lo  = m & 64'hFF;
      add = (lo * f) >> 8;
      if (hi > Q8_LIMIT / f) return CAP_SAT;
      t = hi * f;
      if (t > Q8_LIMIT - add) return CAP_SAT;
      m = t + add;
    end
    return m >> 8;
  endfunction

  // One xorshift64* step: the state advances, the product is the draw.
  function automatic logic [63:0] next_draw();
    logic [63:0] x;
    x = shadow_rng;
    x ^= x >> 12;
    x ^= x << 25;
    x ^= x >> 27;
    shadow_rng = x;
    return x * RNG_MUL;
  endfunction

  // Result word for one accepted input word; updates the shadow state.
  function automatic out_word_t schedule_word(input in_word_t w);
    out_word_t   r;
    logic [63:0] cap, half, draw, delay;
    int          limit;
    r = '0;
    r.retry_at_ns = w.now_ns;
    if (w.kind == KIND_START) begin
      shadow_count = '0;
      return r;
    end
    limit = $signed(shadow_retries);
    if (limit == -1 || int'(shadow_count) < limit) begin
      if (shadow_count != COUNT_MAX) shadow_count++;
      cap  = backoff_cap(shadow_count);
      half = cap >> 1;
      draw = next_draw();
      if (shadow_full) delay = draw % (cap + 64'd1);
      else delay = half + draw % (half + 64'd1);
      // The floor goes first, so a ceiling below the floor still wins.
      if (shadow_floor != '0 && delay < 64'(shadow_floor)) delay = 64'(shadow_floor);
      if (shadow_ceiling != '0 && delay > 64'(shadow_ceiling)) delay = 64'(shadow_ceiling);
      r.granted     = 1'b1;
      r.backoff_ms  = delay[DELAY_W-1:0];
      r.retry_at_ns = w.now_ns + delay * MS_TO_NS;
    end
    r.attempt_number = shadow_count[ATTEMPT_W-1:0];
    return r;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] value);
    case (idx)
      REG_FACTOR:  shadow_factor  = value[11:0];
      REG_MIN:     shadow_floor   = value;
      REG_MAX:     shadow_ceiling = value;
      REG_JITTER:  shadow_full    = value[0];
      REG_RETRIES: shadow_retries = value[8:0];
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("MISMATCH @%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Every result word taken by the receiver is compared, field by field,
  // with the oldest word still owed.
  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result word %h", out_word));
      end else begin
        want = due_results.pop_front();
        if (out_word.granted !== want.granted)
          flag_mismatch($sformatf("granted %b, want %b", out_word.granted, want.granted));
        if (out_word.attempt_number !== want.attempt_number)
          flag_mismatch($sformatf("attempt_number %0d, want %0d",
                                  out_word.attempt_number, want.attempt_number));
        if (out_word.backoff_ms !== want.backoff_ms)
          flag_mismatch($sformatf("backoff_ms %0d, want %0d",
                                  out_word.backoff_ms, want.backoff_ms));
        if (out_word.retry_at_ns !== want.retry_at_ns)
          flag_mismatch($sformatf("retry_at_ns %h, want %h",
                                  out_word.retry_at_ns, want.retry_at_ns));
      end
    end
  end

  // The watchdog ends the run as failed once the stretch without a handshake of
  // any kind reaches the STALL_LIMIT bound.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts between free stretches, one long hold-off on
  // request, and no stalling at all once quiet is set.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int burst, free_run;
    burst    = 0;
    free_run = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        burst    = HOLD_CYCLES;
        free_run = 0;
      end else if (quiet) begin
        burst = 0;
      end else if (burst == 0 && free_run == 0) begin
        if ($urandom_range(0, 2) == 0)
          burst = $urandom_range(1, 9);
        else
          free_run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 20);
      end
      if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else begin
        if (free_run > 0) free_run--;
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offers one word and holds it until it is taken. Valid is left high so
  // that the next word can follow in the very next cycle; the word's result
  // is queued at the edge where the block takes it.
  task automatic offer_word(input kind_t k, input logic [63:0] now, input bit typed,
                            input out_word_t given);
    in_word_t  w;
    out_word_t guess;
    w.kind   = k;
    w.now_ns = now;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    guess = schedule_word(w);
    due_results.push_back(typed ? given : guess);
    words_sent++;
    if (words_sent >= ITEMS - QUIET_ITEMS) quiet = 1'b1;
  endtask

  // Sender idling: a random gap after about one word in four.
  task automatic maybe_pause(input bit calm);
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every owed result has come back. Every
  // word causes a result, so the block is idle at that point.
  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, then an idle phase with psel low so that a
  // following write never lowers and raises psel in the same step.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    apply_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] random_now();
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return ALL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void plan_reg(input logic [2:0] idx, input logic [31:0] value);
    plan_row_t row;
    row.what   = ROW_REG;
    row.idx    = idx;
    row.value  = value;
    row.kind   = KIND_START;
    row.now    = '0;
    row.typed  = 1'b0;
    row.result = '0;
    plan.push_back(row);
  endfunction

  function automatic void plan_word(input kind_t k, input logic [63:0] now);
    plan_row_t row;
    row.what   = ROW_WORD;
    row.idx    = '0;
    row.value  = '0;
    row.kind   = k;
    row.now    = now;
    row.typed  = 1'b0;
    row.result = '0;
    plan.push_back(row);
  endfunction

  function automatic void plan_typed(input kind_t k, input logic [63:0] now, input logic g,
                                     input logic [ATTEMPT_W-1:0] a,
                                     input logic [DELAY_W-1:0] d, input logic [63:0] at);
    plan_word(k, now);
    plan[plan.size()-1].typed                 = 1'b1;
    plan[plan.size()-1].result.granted        = g;
    plan[plan.size()-1].result.attempt_number = a;
    plan[plan.size()-1].result.backoff_ms     = d;
    plan[plan.size()-1].result.retry_at_ns    = at;
  endfunction

  // Directed plan. Rows with a hand-typed result are the ones that can be
  // read off directly: refusals, start words, and delays pinned by a floor or
  // ceiling or by a zero cap. The attempt count runs up across rows.
  function automatic void build_plan();
    // Out of reset the limit is zero, so the first retry is refused.
    plan_typed(KIND_RETRY, 64'd0, 1'b0, 16'd0, 40'd0, 64'd0);
    plan_typed(KIND_START, ALL_ONES, 1'b0, 16'd0, 40'd0, ALL_ONES);
    // Bits above the register width are dropped: this is the unlimited code.
    plan_reg(REG_RETRIES, 32'hFFFF_FFFF);
    plan_word(KIND_RETRY, 64'd1000);
    plan_word(KIND_RETRY, 64'h0123_4567_89AB_CDEF);
    plan_reg(REG_JITTER, 32'hFFFF_FFFE);
    plan_word(KIND_RETRY, 64'h8000_0000_0000_0000);
    // Floor equal to ceiling pins the delay; the retry time wraps.
    plan_reg(REG_MIN, 32'd7);
    plan_reg(REG_MAX, 32'd7);
    plan_typed(KIND_RETRY, ALL_ONES, 1'b1, 16'd4, 40'd7, 64'd7 * MS_TO_NS - 64'd1);
    // Floor above the ceiling: the ceiling wins.
    plan_reg(REG_MIN, 32'd1000);
    plan_typed(KIND_RETRY, 64'd0, 1'b1, 16'd5, 40'd7, 64'd7 * MS_TO_NS);
    // Largest floor with no ceiling lifts the small cap to the floor.
    plan_reg(REG_MIN, 32'hFFFF_FFFF);
    plan_reg(REG_MAX, 32'd0);
    plan_typed(KIND_RETRY, 64'd0, 1'b1, 16'd6, 40'hFFFF_FFFF, 64'hFFFF_FFFF * MS_TO_NS);
    // Largest factor drives the cap into saturation within a few attempts.
    plan_reg(REG_MIN, 32'd0);
    plan_reg(REG_MAX, 32'hFFFF_FFFF);
    plan_reg(REG_FACTOR, 32'hFFFF_FFFF);
    plan_word(KIND_RETRY, 64'd11);
    plan_word(KIND_RETRY, 64'hDEAD_BEEF_0000_0001);
    plan_word(KIND_RETRY, 64'h7FFF_FFFF_FFFF_FFFF);
    plan_reg(REG_MAX, 32'd0);
    plan_word(KIND_RETRY, 64'hFFFF_FFFF_0000_0000);
    // Zero factor stands for 2.0.
    plan_reg(REG_FACTOR, 32'd0);
    plan_word(KIND_RETRY, 64'd5);
    // Smallest factor shrinks the cap to zero, so the delay is zero.
    plan_reg(REG_FACTOR, 32'd1);
    plan_typed(KIND_RETRY, 64'd99, 1'b1, 16'd12, 40'd0, 64'd99);
    plan_typed(KIND_START, 64'd123, 1'b0, 16'd0, 40'd0, 64'd123);
    // A limit of two: the third retry is refused and leaves the count.
    plan_reg(REG_FACTOR, 32'(FACTOR_DEFAULT));
    plan_reg(REG_RETRIES, 32'd2);
    plan_word(KIND_RETRY, 64'd1);
    plan_word(KIND_RETRY, 64'd2);
    plan_typed(KIND_RETRY, 64'd3, 1'b0, 16'd2, 40'd0, 64'd3);
    // A negative limit other than unlimited refuses everything.
    plan_reg(REG_RETRIES, 32'(RETRIES_REFUSE_ALL));
    plan_typed(KIND_START, 64'd0, 1'b0, 16'd0, 40'd0, 64'd0);
    plan_typed(KIND_RETRY, 64'd77, 1'b0, 16'd0, 40'd0, 64'd77);
    // Writes past the register map must change nothing; the grants below
    // would show a floor or factor that got hit by mistake.
    plan_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    plan_reg(REG_SPARE_HI, 32'h0000_0000);
    plan_reg(REG_RETRIES, 32'd255);
    plan_reg(REG_JITTER, 32'd1);
    plan_word(KIND_RETRY, 64'h0000_0001_0000_0000);
    plan_word(KIND_RETRY, 64'hFEDC_BA98_7654_3210);
  endfunction

  // One random phase: outside the quiet stretch, wait for idle and pick new
  // register settings; then send a batch of mostly well-formed sequences (a
  // start word followed by a run of retries) with some words of random kind
  // mixed in.
  task automatic run_phase();
    logic [31:0] v;
    int          seqs, s, run;
    bit          calm;
    if (!quiet) begin
      settle();
      case ($urandom_range(0, 7))
        0:       v = 32'd0;
        1:       v = 32'd1;
        2:       v = 32'd4095;
        3:       v = 32'd256;
        4:       v = 32'(FACTOR_DEFAULT);
        5, 6:    v = $urandom_range(256, 1024);
        default: v = $urandom;
      endcase
      write_reg(REG_FACTOR, v);
      case ($urandom_range(0, 7))
        4:       v = $urandom_range(1, 500);
        5:       v = 32'hFFFF_FFFF;
        6:       v = $urandom;
        default: v = 32'd0;
      endcase
      write_reg(REG_MIN, v);
      case ($urandom_range(0, 6))
        3:       v = $urandom_range(1, 5000);
        4:       v = 32'hFFFF_FFFF;
        5:       v = $urandom;
        default: v = 32'd0;
      endcase
      write_reg(REG_MAX, v);
      write_reg(REG_JITTER, $urandom);
      case ($urandom_range(0, 7))
        0, 1:    v = {23'($urandom_range(0, 32'h7F_FFFF)), RETRIES_UNLIMITED};
        2:       v = 32'd0;
        3:       v = 32'd255;
        4:       v = 32'(RETRIES_REFUSE_ALL);
        5:       v = $urandom_range(1, 20);
        default: v = $urandom;
      endcase
      write_reg(REG_RETRIES, v);
      if ($urandom_range(0, 3) == 0)
        write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
    end

    calm = ($urandom_range(0, 2) == 0);
    // Once, well into the run, the receiver holds off for a long stretch
    // while this phase keeps offering words back to back.
    if (!hold_done && words_sent >= 400) begin
      hold_done = 1'b1;
      hold_req  = 1'b1;
      calm      = 1'b1;
    end

    seqs = $urandom_range(3, 10);
    for (s = 0; s < seqs && words_sent < ITEMS; s++) begin
      if ($urandom_range(0, 9) < 8) begin
        offer_word(KIND_START, random_now(), 1'b0, '0);
        maybe_pause(calm);
        run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 10);
        repeat (run) begin
          offer_word(KIND_RETRY, random_now(), 1'b0, '0);
          maybe_pause(calm);
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          offer_word(kind_t'($urandom_range(0, 1)), random_now(), 1'b0, '0);
          maybe_pause(calm);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, the directed plan, random phases, then the drain.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    shadow_factor  = FACTOR_DEFAULT;
    shadow_floor   = '0;
    shadow_ceiling = '0;
    shadow_full    = 1'b1;
    shadow_retries = '0;
    shadow_rng     = RNG_SEED;
    shadow_count   = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_plan();
    foreach (plan[n]) begin
      if (plan[n].what == ROW_REG) begin
        // Registers only change while the block has nothing in flight.
        settle();
        write_reg(plan[n].idx, plan[n].value);
      end else begin
        offer_word(plan[n].kind, plan[n].now, plan[n].typed, plan[n].result);
      end
    end

    while (words_sent < ITEMS) run_phase();

    // Wait for every owed word, then a little over one worst-case latency so
    // that a stray extra result would still be caught.
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### jittered_retry_backoff.f
src/jrb_pkg.sv
src/jrb_mul.sv
src/jrb_mod.sv
src/jittered_retry_backoff.sv
tb/sv/testbench.sv
